### src/dqpc_pkg.sv
// Package of shared constants, types and count helpers for the dual quadrature counter.
package dqpc_pkg;

  // Width of the internal rotary and linear counters.
  localparam int COUNT_WIDTH = 16;
  // Width of the modulus register and of the position fields.
  localparam int MOD_WIDTH = 15;
  localparam int POS_WIDTH = 16;
  // Reset value of the modulus register.
  localparam logic [MOD_WIDTH-1:0] MODULUS_RESET = MOD_WIDTH'(2400);
  // Compare width that holds both a count and a negated modulus without overflow.
  localparam int FOLD_WIDTH = ((COUNT_WIDTH > POS_WIDTH) ? COUNT_WIDTH : POS_WIDTH) + 2;
  // Depth of the result buffer.
  localparam int BUF_DEPTH = 2;

  typedef logic signed [COUNT_WIDTH-1:0] count_t;
  typedef logic signed [POS_WIDTH-1:0] pos_t;

  typedef struct packed {
    pos_t rotary_position;
    pos_t linear_position;
  } dqpc_result_t;

  // One count step up or down, wrapping in the counter width.
  function automatic count_t count_step(input count_t c, input logic up);
    count_step = up ? count_t'(c + count_t'(1)) : count_t'(c - count_t'(1));
  endfunction

  // Folds the rotary count back once by the modulus when its magnitude reaches it.
  function automatic count_t fold_rotary(input count_t c, input logic [MOD_WIDTH-1:0] m);
    logic signed [FOLD_WIDTH-1:0] cw;
    logic signed [FOLD_WIDTH-1:0] mw;
    logic signed [FOLD_WIDTH-1:0] r;
    cw = FOLD_WIDTH'(c);
    mw = signed'(FOLD_WIDTH'(m));
    if (cw <= -mw) begin
      r = cw + mw;
    end else if (cw >= mw) begin
      r = cw - mw;
    end else begin
      r = cw;
    end
    fold_rotary = count_t'(r);
  endfunction

  // Low position bits of a count, sign extended when the counter is narrower.
  function automatic pos_t to_pos(input count_t c);
    logic signed [31:0] ext;
    ext = 32'(c);
    to_pos = ext[POS_WIDTH-1:0];
  endfunction

endpackage

### src/dqpc_ifs.sv
// Channel interfaces: encoder sample input, position result output and modulus write.
interface dqpc_sample_if;
  logic valid;
  logic ready;
  logic rot_a_level;
  logic rot_b_level;
  logic lin_a_level;
  logic lin_b_level;
  logic clear_rotary;

  modport source (output valid, rot_a_level, rot_b_level, lin_a_level, lin_b_level,
                  clear_rotary, input ready);
  modport sink (input valid, rot_a_level, rot_b_level, lin_a_level, lin_b_level,
                clear_rotary, output ready);
endinterface

interface dqpc_result_if;
  logic valid;
  logic ready;
  logic signed [15:0] rotary_position;
  logic signed [15:0] linear_position;

  modport source (output valid, rotary_position, linear_position, input ready);
  modport sink (input valid, rotary_position, linear_position, output ready);
endinterface

interface dqpc_cfg_if;
  logic valid;
  logic ready;
  logic [14:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### src/dual_quadrature_position_counter.sv
// A result is registered into the result buffer when its sample beat is accepted;
// one sample beat per cycle unless the buffer is full. Decode and count update are
// one pass of logic. A two-entry result buffer lets sampling go on while one result
// waits downstream. Reset (synchronous, active high) zeroes both counts and stored
// levels, empties the buffer and loads the counts-per-revolution modulus with 2400.
module dual_quadrature_position_counter
  import dqpc_pkg::*;
(
  input logic clk,
  input logic rst,
  dqpc_cfg_if.sink cfg,
  dqpc_sample_if.sink sample,
  dqpc_result_if.source result
);

  logic [MOD_WIDTH-1:0] rotary_modulus;
  logic rot_a_last, rot_b_last, lin_a_last, lin_b_last;
  count_t rotary_count, linear_count;
  count_t rotary_count_next, linear_count_next;

  dqpc_result_t slot [BUF_DEPTH];
  logic [1:0] fill;
  logic push, pop;
  dqpc_result_t new_result;

  // The modulus register takes every write beat.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotary_modulus <= MODULUS_RESET;
    end else if (cfg.valid) begin
      rotary_modulus <= cfg.data;
    end
  end

  // Edge decode: A is handled before B, each rotary edge folds once.
  always_comb begin
    count_t r;
    count_t l;
    r = rotary_count;
    l = linear_count;
    if (sample.rot_a_level != rot_a_last) begin
      r = fold_rotary(count_step(r, rot_b_last ^ rot_a_last), rotary_modulus);
    end
    if (sample.rot_b_level != rot_b_last) begin
      r = fold_rotary(count_step(r, sample.rot_b_level ^ sample.rot_a_level),
                      rotary_modulus);
    end
    if (sample.lin_a_level != lin_a_last) begin
      l = count_step(l, lin_b_last ^ lin_a_last);
    end
    if (sample.lin_b_level != lin_b_last) begin
      l = count_step(l, sample.lin_b_level ^ sample.lin_a_level);
    end
    if (sample.clear_rotary) begin
      r = '0;
    end
    rotary_count_next = r;
    linear_count_next = l;
  end

  assign push = sample.valid && sample.ready;
  assign pop = result.valid && result.ready;
  assign new_result.rotary_position = to_pos(rotary_count_next);
  assign new_result.linear_position = to_pos(linear_count_next);

  // Encoder state advances on every accepted sample beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_a_last <= 1'b0;
      rot_b_last <= 1'b0;
      lin_a_last <= 1'b0;
      lin_b_last <= 1'b0;
      rotary_count <= '0;
      linear_count <= '0;
    end else if (push) begin
      rot_a_last <= sample.rot_a_level;
      rot_b_last <= sample.rot_b_level;
      lin_a_last <= sample.lin_a_level;
      lin_b_last <= sample.lin_b_level;
      rotary_count <= rotary_count_next;
      linear_count <= linear_count_next;
    end
  end

  // Result buffer fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (push && !pop) begin
      fill <= fill + 2'd1;
    end else if (pop && !push) begin
      fill <= fill - 2'd1;
    end
  end

  // Result buffer payload: slot 0 is the head.
  always_ff @(posedge clk) begin
    if (pop) begin
      slot[0] <= push ? new_result : slot[1];
    end else if (push && fill == 2'd0) begin
      slot[0] <= new_result;
    end
    if (push && !pop && fill == 2'd1) begin
      slot[1] <= new_result;
    end
  end

  assign sample.ready = (fill != 2'(BUF_DEPTH));
  assign result.valid = (fill != 2'd0);
  assign result.rotary_position = slot[0].rotary_position;
  assign result.linear_position = slot[0].linear_position;

`ifndef SYNTH
  // The buffer never holds more than its depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= 2'(BUF_DEPTH))
    else $error("result buffer overfilled");

  // A clear request leaves the rotary count at zero.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    push && sample.clear_rotary |=> rotary_count == '0)
    else $error("rotary count not cleared");

  // Without linear edges the linear count holds.
  a_lin_hold: assert property (@(posedge clk) disable iff (rst)
    push && sample.lin_a_level == lin_a_last && sample.lin_b_level == lin_b_last
    |=> $stable(linear_count))
    else $error("linear count moved without an edge");

  // No sample beat, no change of encoder state.
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !push |=> $stable(rotary_count) && $stable(linear_count) && $stable(rot_a_last)
    && $stable(rot_b_last))
    else $error("encoder state changed without a sample beat");

  // A result is only offered when one was pushed or already held.
  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    !result.valid && !push |=> !result.valid)
    else $error("result offered from nowhere");
`endif

endmodule
